### rtl/markov_transition_predictor_defines.svh
// ----------------------------------------------------------------------------
// Markov transition predictor assertion macros
// Shared property forms for the checker of the predictor block.
// ----------------------------------------------------------------------------
`ifndef MARKOV_TRANSITION_PREDICTOR_DEFINES_SVH
`define MARKOV_TRANSITION_PREDICTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markov transition predictor package
// Payload types, control structs and fixed constants of the predictor.
// ----------------------------------------------------------------------------
package mtp_pkg;

  localparam int unsigned StateW   = 4;
  localparam int unsigned UnitIdxW = 4;
  localparam int unsigned DelayW   = 20;
  localparam int unsigned StepW    = 16;
  localparam int unsigned DigitW   = 4;

  localparam logic [StepW-1:0] StepReset   = 16'd2000;
  localparam logic             FuncObserve = 1'b0;

  typedef struct packed {
    logic                func;
    logic [UnitIdxW-1:0] unit_index;
    logic [StateW-1:0]   new_state;
  } mtp_in_t;

  typedef struct packed {
    logic [StateW-1:0] predicted_state;
    logic [StateW-1:0] last_state;
    logic [DelayW-1:0] expected_delay;
    logic [DelayW-1:0] last_delay;
    logic              row_empty;
    logic              bad_state;
  } mtp_out_t;

  // Control of the row accumulator: clear before a walk, then one count per valid.
  typedef struct packed {
    logic              clear;
    logic              valid;
    logic [StateW-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_status_t;

endpackage

### rtl/mtp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Predictor memory
// Simple dual-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mtp_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mtp_row_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Predictor row accumulator
// Takes one count of a transition row per valid cycle and keeps the row
// total, the index-weighted sum and the argmax with the last-state tie rule.
// ----------------------------------------------------------------------------
module mtp_row_scan import mtp_pkg::*; #(
  parameter int unsigned CountW = 16,
  localparam int unsigned TotalW = CountW + 4,
  localparam int unsigned WeightW = CountW + 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scan_ctl_t          ctl_i,
  input  logic [CountW-1:0]  count_i,
  input  logic [StateW-1:0]  last_i,
  output logic [TotalW-1:0]  total_o,
  output logic [WeightW-1:0] weighted_o,
  output logic [StateW-1:0]  predicted_o
);

  logic [TotalW-1:0]  total_q, total_d;
  logic [WeightW-1:0] weighted_q, weighted_d;
  logic [CountW-1:0]  max_q, max_d;
  logic [StateW-1:0]  max_idx_q, max_idx_d;
  logic [CountW-1:0]  last_cnt_q, last_cnt_d;

  always_comb begin
    total_d    = total_q;
    weighted_d = weighted_q;
    max_d      = max_q;
    max_idx_d  = max_idx_q;
    last_cnt_d = last_cnt_q;
    if (ctl_i.clear) begin
      total_d    = '0;
      weighted_d = '0;
      max_d      = '0;
      max_idx_d  = '0;
      last_cnt_d = '0;
    end else if (ctl_i.valid) begin
      total_d    = total_q + TotalW'(count_i);
      weighted_d = weighted_q + WeightW'(count_i) * WeightW'(ctl_i.idx);
      // Counts arrive in ascending index order, so a strict compare keeps the
      // lowest index among equal maxima.
      if (count_i > max_q) begin
        max_d     = count_i;
        max_idx_d = ctl_i.idx;
      end
      if (ctl_i.idx == last_i) begin
        last_cnt_d = count_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      weighted_q <= '0;
      max_q      <= '0;
      max_idx_q  <= '0;
      last_cnt_q <= '0;
    end else begin
      total_q    <= total_d;
      weighted_q <= weighted_d;
      max_q      <= max_d;
      max_idx_q  <= max_idx_d;
      last_cnt_q <= last_cnt_d;
    end
  end

  // The last state wins whenever its own count reaches the maximum.
  assign predicted_o = (last_cnt_q == max_q) ? last_i : max_idx_q;
  assign total_o     = total_q;
  assign weighted_o  = weighted_q;

endmodule

### rtl/mtp_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Predictor mean unit
// Multiplies the weighted sum by the delay step one digit per cycle, then
// divides by the row total one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtp_muldiv import mtp_pkg::*; #(
  parameter int unsigned CountW = 16,
  localparam int unsigned TotalW = CountW + 4,
  localparam int unsigned WeightW = CountW + 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [WeightW-1:0] weighted_i,
  input  logic [TotalW-1:0]  total_i,
  input  logic [StepW-1:0]   step_i,
  output md_status_t         status_o,
  output logic [DelayW-1:0]  quot_o
);

  localparam int unsigned ProdW = WeightW + StepW;
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhMul  = 2'd1;
  localparam logic [1:0] PhDiv  = 2'd2;
  localparam logic [4:0] MulLast = 5'(StepW / DigitW - 1);
  localparam logic [4:0] DivLast = 5'(DelayW - 1);

  logic [1:0]         phase_q, phase_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [WeightW-1:0] wgt_q, wgt_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [TotalW-1:0]  tot_q, tot_d;
  logic [TotalW-1:0]  rem_q, rem_d;
  logic [DelayW-1:0]  lo_q, lo_d;
  logic [DelayW-1:0]  quot_q, quot_d;
  logic [TotalW:0]    trial;
  logic [ProdW-1:0]   partial;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    prod_d  = prod_q;
    wgt_d   = wgt_q;
    step_d  = step_q;
    tot_d   = tot_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    quot_d  = quot_q;
    trial   = {rem_q, lo_q[DelayW-1]};
    partial = ProdW'(wgt_q) * ProdW'(step_q[StepW-1 -: DigitW]);
    unique case (phase_q)
      PhIdle: begin
        if (start_i) begin
          phase_d = PhMul;
          cnt_d   = '0;
          prod_d  = '0;
          wgt_d   = weighted_i;
          step_d  = step_i;
          tot_d   = total_i;
        end
      end
      PhMul: begin
        prod_d = (prod_q << DigitW) + partial;
        step_d = step_q << DigitW;
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == MulLast) begin
          phase_d = PhDiv;
          cnt_d   = '0;
        end
      end
      PhDiv: begin
        if (trial >= {1'b0, tot_q}) begin
          rem_d  = TotalW'(trial - {1'b0, tot_q});
          quot_d = {quot_q[DelayW-2:0], 1'b1};
        end else begin
          rem_d  = trial[TotalW-1:0];
          quot_d = {quot_q[DelayW-2:0], 1'b0};
        end
        lo_d  = lo_q << 1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DivLast) begin
          phase_d = PhIdle;
          done_d  = 1'b1;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
    // Load the divider from the finished product on the last multiply step.
    // The quotient fits in DelayW bits, so the upper product bits are already
    // below the divisor and seed the remainder.
    if (phase_q == PhMul && cnt_q == MulLast) begin
      rem_d  = prod_d[ProdW-1:DelayW];
      lo_d   = prod_d[DelayW-1:0];
      quot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      prod_q  <= '0;
      wgt_q   <= '0;
      step_q  <= '0;
      tot_q   <= '0;
      rem_q   <= '0;
      lo_q    <= '0;
      quot_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      prod_q  <= prod_d;
      wgt_q   <= wgt_d;
      step_q  <= step_d;
      tot_q   <= tot_d;
      rem_q   <= rem_d;
      lo_q    <= lo_d;
      quot_q  <= quot_d;
    end
  end

  assign status_o.busy = (phase_q != PhIdle);
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule

### rtl/markov_transition_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markov transition predictor
// Bank of first-order Markov next-state predictors kept in on-chip RAM.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+------------------------
//  in      | input     | in_valid_i / in_stall_o   | mtp_in_t  in_data_i
//  out     | output    | out_valid_o / out_stall_i | mtp_out_t out_data_o
//  cfg     | input     | cfg_we_i (no wait)        | cfg_wdata_i delay step
//
// One transaction at a time. A query passes through the row walk (one RAM
// read per count) and the mean unit (4 multiply digits, then 20 quotient
// bits); an observe also passes an update state before the walk. After
// reset a clearing pass writes NUM_UNITS * NUM_STATES * NUM_STATES RAM
// entries, one per cycle, with in_stall_o high. A stalled result holds in
// the output register while the next transaction is taken and computed.
// ----------------------------------------------------------------------------
module markov_transition_predictor import mtp_pkg::*; #(
  parameter int unsigned NUM_STATES  = 10,
  parameter int unsigned NUM_UNITS   = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mtp_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mtp_out_t         out_data_o,
  input  logic             cfg_we_i,
  input  logic [StepW-1:0] cfg_wdata_i
);

  localparam int unsigned UnitW    = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int unsigned NumSq    = NUM_STATES * NUM_STATES;
  localparam int unsigned CntDepth = NUM_UNITS * NumSq;
  localparam int unsigned CntAddrW = $clog2(CntDepth);
  localparam int unsigned ScanW    = $clog2(NUM_STATES + 1);
  localparam int unsigned TotalW   = COUNT_WIDTH + 4;
  localparam int unsigned WeightW  = COUNT_WIDTH + 8;

  localparam logic [StateW:0]      NumStatesExt = (StateW + 1)'(NUM_STATES);
  localparam logic [ScanW-1:0]     ScanEnd      = ScanW'(NUM_STATES);
  localparam logic [CntAddrW-1:0]  ClrLast      = CntAddrW'(CntDepth - 1);
  localparam logic [CntAddrW-1:0]  ClrUnits     = CntAddrW'(NUM_UNITS);
  localparam logic [CntAddrW-1:0]  RowStride    = CntAddrW'(NUM_STATES);
  localparam logic [CntAddrW-1:0]  UnitStride   = CntAddrW'(NumSq);
  localparam logic [COUNT_WIDTH-1:0] CountMax   = {COUNT_WIDTH{1'b1}};

  localparam logic [2:0] StClear    = 3'd0;
  localparam logic [2:0] StIdle     = 3'd1;
  localparam logic [2:0] StPrev     = 3'd2;
  localparam logic [2:0] StUpd      = 3'd3;
  localparam logic [2:0] StScan     = 3'd4;
  localparam logic [2:0] StMathGo   = 3'd5;
  localparam logic [2:0] StMathWait = 3'd6;
  localparam logic [2:0] StOut      = 3'd7;

  logic [2:0]             state_q, state_d;
  logic [CntAddrW-1:0]    clr_q, clr_d;
  logic [StepW-1:0]       step_q, step_d;
  mtp_in_t                item_q, item_d;
  logic [UnitW-1:0]       unit_q, unit_d;
  logic [StateW-1:0]      last_q, last_d;
  logic                   bad_q, bad_d;
  logic [CntAddrW-1:0]    upd_addr_q, upd_addr_d;
  logic [CntAddrW-1:0]    row_base_q, row_base_d;
  logic [ScanW-1:0]       scan_cnt_q, scan_cnt_d;
  logic                   scan_vld_q, scan_vld_d;
  logic [StateW-1:0]      scan_idx_q, scan_idx_d;
  logic [DelayW-1:0]      last_delay_q, last_delay_d;
  logic                   out_valid_q, out_valid_d;
  mtp_out_t               out_data_q, out_data_d;

  logic [UnitW-1:0]       wrap_tbl [16];
  logic                   accept;
  logic [StateW-1:0]      prev_clamped;
  logic                   obs_bad;
  logic                   do_upd;
  logic                   scan_issue;
  logic                   out_free;

  logic                   cnt_we, cnt_re;
  logic [CntAddrW-1:0]    cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
  logic                   prev_we;
  logic [UnitW-1:0]       prev_waddr;
  logic [StateW-1:0]      prev_wdata, prev_rdata;

  scan_ctl_t              scan_ctl;
  logic [TotalW-1:0]      row_total;
  logic [WeightW-1:0]     row_weighted;
  logic [StateW-1:0]      row_predicted;
  md_status_t             md_status;
  logic [DelayW-1:0]      md_quot;

  // Unit index reduced modulo NUM_UNITS through a constant table.
  for (genvar k = 0; k < 16; k++) begin : g_wrap
    assign wrap_tbl[k] = UnitW'(k % NUM_UNITS);
  end

  assign accept       = in_valid_i && !in_stall_o;
  assign in_stall_o   = (state_q != StIdle);
  assign prev_clamped = ({1'b0, prev_rdata} >= NumStatesExt) ? '0 : prev_rdata;
  assign obs_bad      = (item_q.func == FuncObserve) &&
                        ({1'b0, item_q.new_state} >= NumStatesExt);
  assign do_upd       = (item_q.func == FuncObserve) && !obs_bad;
  assign scan_issue   = (state_q == StScan) && (scan_cnt_q < ScanEnd);
  assign out_free     = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    step_d       = cfg_we_i ? cfg_wdata_i : step_q;
    item_d       = item_q;
    unit_d       = unit_q;
    last_d       = last_q;
    bad_d        = bad_q;
    upd_addr_d   = upd_addr_q;
    row_base_d   = row_base_q;
    scan_cnt_d   = scan_cnt_q;
    scan_vld_d   = scan_issue;
    scan_idx_d   = StateW'(scan_cnt_q);
    last_delay_d = last_delay_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;

    unique case (state_q)
      StClear: begin
        clr_d = clr_q + CntAddrW'(1);
        if (clr_q == ClrLast) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          item_d  = in_data_i;
          unit_d  = wrap_tbl[in_data_i.unit_index];
          state_d = StPrev;
        end
      end
      StPrev: begin
        bad_d      = obs_bad;
        scan_cnt_d = '0;
        upd_addr_d = CntAddrW'(unit_q) * UnitStride +
                     CntAddrW'(prev_clamped) * RowStride + CntAddrW'(item_q.new_state);
        if (do_upd) begin
          last_d     = item_q.new_state;
          row_base_d = CntAddrW'(unit_q) * UnitStride +
                       CntAddrW'(item_q.new_state) * RowStride;
          state_d    = StUpd;
        end else begin
          last_d     = prev_clamped;
          row_base_d = CntAddrW'(unit_q) * UnitStride +
                       CntAddrW'(prev_clamped) * RowStride;
          state_d    = StScan;
        end
      end
      StUpd: begin
        state_d = StScan;
      end
      StScan: begin
        if (scan_issue) begin
          scan_cnt_d = scan_cnt_q + ScanW'(1);
        end else begin
          // The last count is taken by the accumulator at this edge.
          state_d = StMathGo;
        end
      end
      StMathGo: begin
        last_delay_d = DelayW'(last_q) * DelayW'(step_q);
        state_d      = StMathWait;
      end
      StMathWait: begin
        if (md_status.done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_data_d.predicted_state = row_predicted;
          out_data_d.last_state      = last_q;
          out_data_d.expected_delay  = (row_total == '0) ? '0 : md_quot;
          out_data_d.last_delay      = last_delay_q;
          out_data_d.row_empty       = (row_total == '0);
          out_data_d.bad_state       = bad_q;
          state_d                    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // RAM port steering.
  always_comb begin
    cnt_we     = 1'b0;
    cnt_waddr  = upd_addr_q;
    cnt_wdata  = (cnt_rdata == CountMax) ? cnt_rdata : cnt_rdata + COUNT_WIDTH'(1);
    cnt_re     = scan_issue;
    cnt_raddr  = row_base_q + CntAddrW'(scan_cnt_q);
    prev_we    = 1'b0;
    prev_waddr = unit_q;
    prev_wdata = item_q.new_state;
    if (state_q == StClear) begin
      cnt_we     = 1'b1;
      cnt_waddr  = clr_q;
      cnt_wdata  = '0;
      prev_we    = (clr_q < ClrUnits);
      prev_waddr = clr_q[UnitW-1:0];
      prev_wdata = '0;
    end else if (state_q == StPrev) begin
      cnt_re    = do_upd;
      cnt_raddr = upd_addr_d;
    end else if (state_q == StUpd) begin
      cnt_we  = 1'b1;
      prev_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      clr_q        <= '0;
      step_q       <= StepReset;
      item_q       <= '0;
      unit_q       <= '0;
      last_q       <= '0;
      bad_q        <= 1'b0;
      upd_addr_q   <= '0;
      row_base_q   <= '0;
      scan_cnt_q   <= '0;
      scan_vld_q   <= 1'b0;
      scan_idx_q   <= '0;
      last_delay_q <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      step_q       <= step_d;
      item_q       <= item_d;
      unit_q       <= unit_d;
      last_q       <= last_d;
      bad_q        <= bad_d;
      upd_addr_q   <= upd_addr_d;
      row_base_q   <= row_base_d;
      scan_cnt_q   <= scan_cnt_d;
      scan_vld_q   <= scan_vld_d;
      scan_idx_q   <= scan_idx_d;
      last_delay_q <= last_delay_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
    end
  end

  mtp_ram #(
    .Depth (CntDepth),
    .Width (COUNT_WIDTH)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  mtp_ram #(
    .Depth (NUM_UNITS),
    .Width (StateW)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (accept),
    .raddr_i (wrap_tbl[in_data_i.unit_index]),
    .rdata_o (prev_rdata)
  );

  assign scan_ctl.clear = (state_q == StPrev);
  assign scan_ctl.valid = scan_vld_q;
  assign scan_ctl.idx   = scan_idx_q;

  mtp_row_scan #(
    .CountW (COUNT_WIDTH)
  ) u_row_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .count_i     (cnt_rdata),
    .last_i      (last_q),
    .total_o     (row_total),
    .weighted_o  (row_weighted),
    .predicted_o (row_predicted)
  );

  mtp_muldiv #(
    .CountW (COUNT_WIDTH)
  ) u_muldiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == StMathGo),
    .weighted_i (row_weighted),
    .total_i    (row_total),
    .step_i     (step_q),
    .status_o   (md_status),
    .quot_o     (md_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/mtp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markov transition predictor checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "markov_transition_predictor_defines.svh"

module mtp_checker import mtp_pkg::*; #(
  parameter int unsigned NUM_STATES = 10
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_i,
  input logic     out_stall_i,
  input mtp_out_t out_data_i
);

  // A stalled result must stay put until it is taken.
  `MTP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i), "stalled result changed")

  // An empty row reports no delay and keeps the last state as prediction.
  `MTP_ASSERT_NOW(a_empty_row, clk_i, rst_ni, out_valid_i && out_data_i.row_empty, (out_data_i.expected_delay == '0) && (out_data_i.predicted_state == out_data_i.last_state), "empty row result inconsistent")

  // Reported states always lie inside the state space.
  `MTP_ASSERT_NOW(a_state_range, clk_i, rst_ni, out_valid_i, (int'(out_data_i.last_state) < NUM_STATES) && (int'(out_data_i.predicted_state) < NUM_STATES), "reported state out of range")

endmodule

bind markov_transition_predictor mtp_checker #(
  .NUM_STATES (NUM_STATES)
) u_mtp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

### tb/markov_transition_predictor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Markov transition predictor testbench
// Drives request transactions with random gaps and random result stalls,
// predicts every report from a private copy of the count matrices, and
// checks each accepted report field by field in order of arrival.
// ----------------------------------------------------------------------------
module markov_transition_predictor_test;
  import mtp_pkg::*;

  localparam int unsigned NumStates = 10;
  localparam int unsigned NumUnits  = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned CountMax  = (1 << CountW) - 1;
  localparam logic        FuncQuery = ~FuncObserve;
  localparam int unsigned MaxShown  = 10;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned PhaseLen  = 320;

  // Scoreboard: shadow count matrices and the queue of predicted reports.
  class markov_scoreboard;
    bit [CountW-1:0] counts [NumUnits][NumStates][NumStates];
    bit [StateW-1:0] last_seen [NumUnits];
    bit [StepW-1:0]  step;
    mtp_out_t        predicted_reports [$];
    int unsigned     mismatches;
    int unsigned     n_requests;
    int unsigned     n_observes;
    int unsigned     n_out_of_range;
    int unsigned     n_empty_rows;
    int unsigned     n_checked;

    function new();
      step = StepReset;
    endfunction

    function void take_request(mtp_in_t item);
      mtp_out_t        rep;
      int unsigned     u;
      int unsigned     cur;
      int unsigned     best;
      int unsigned     best_cnt;
      int unsigned     i;
      longint unsigned total;
      longint unsigned weighted;
      u   = item.unit_index % NumUnits;
      cur = last_seen[u];
      if (cur >= NumStates) cur = 0;
      rep = '0;
      n_requests++;
      if (item.func == FuncObserve) begin
        n_observes++;
        if (item.new_state >= NumStates) begin
          rep.bad_state = 1'b1;
          n_out_of_range++;
        end else begin
          if (counts[u][cur][item.new_state] != CountMax)
            counts[u][cur][item.new_state]++;
          last_seen[u] = item.new_state;
          cur = item.new_state;
        end
      end
      // The last state is the first candidate, so it keeps ties.
      best     = cur;
      best_cnt = counts[u][cur][cur];
      total    = 0;
      weighted = 0;
      for (i = 0; i < NumStates; i++) begin
        if (counts[u][cur][i] > best_cnt) begin
          best_cnt = counts[u][cur][i];
          best     = i;
        end
        total    += counts[u][cur][i];
        weighted += longint'(counts[u][cur][i]) * i;
      end
      rep.predicted_state = StateW'(best);
      rep.last_state      = StateW'(cur);
      rep.expected_delay  = (total != 0) ? DelayW'((weighted * step) / total) : '0;
      rep.last_delay      = DelayW'(cur * step);
      rep.row_empty       = (total == 0);
      if (total == 0) n_empty_rows++;
      predicted_reports.push_back(rep);
    endfunction

    function void check_report(mtp_out_t got);
      mtp_out_t exp;
      string    bad;
      if (predicted_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("unexpected result transaction at %0t: pred=%0d last=%0d", $realtime,
                   got.predicted_state, got.last_state);
        return;
      end
      exp = predicted_reports.pop_front();
      n_checked++;
      bad = "";
      if (got.predicted_state !== exp.predicted_state) bad = {bad, " predicted_state"};
      if (got.last_state !== exp.last_state) bad = {bad, " last_state"};
      if (got.expected_delay !== exp.expected_delay) bad = {bad, " expected_delay"};
      if (got.last_delay !== exp.last_delay) bad = {bad, " last_delay"};
      if (got.row_empty !== exp.row_empty) bad = {bad, " row_empty"};
      if (got.bad_state !== exp.bad_state) bad = {bad, " bad_state"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= MaxShown) begin
          $display("mismatch at %0t in%s", $realtime, bad);
          $display("  expected pred=%0d last=%0d exp_delay=%0d last_delay=%0d empty=%0b bad=%0b",
                   exp.predicted_state, exp.last_state, exp.expected_delay,
                   exp.last_delay, exp.row_empty, exp.bad_state);
          $display("  actual   pred=%0d last=%0d exp_delay=%0d last_delay=%0d empty=%0b bad=%0b",
                   got.predicted_state, got.last_state, got.expected_delay,
                   got.last_delay, got.row_empty, got.bad_state);
        end
      end
    endfunction

    function int unsigned pending();
      return predicted_reports.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  mtp_in_t          in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  mtp_out_t         out_data_o;
  logic             cfg_we_i    = 1'b0;
  logic [StepW-1:0] cfg_wdata_i = '0;

  bit               in_gapless  = 1'b0;
  bit               out_gapless = 1'b0;
  int unsigned      n_settings  = 1;

  markov_scoreboard sb = new();

  markov_transition_predictor #(
    .NUM_STATES (NumStates),
    .NUM_UNITS  (NumUnits),
    .COUNT_WIDTH(CountW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // Result monitor: a transaction completes when valid is high and stall is low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_report(out_data_o);
  end

  // Result stall: hold the stall for a drawn number of cycles on a waiting result.
  initial begin
    int unsigned hold;
    forever begin
      hold = out_gapless ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (hold - 1) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic mtp_in_t make_request(logic func, int unsigned unit, int unsigned st);
    mtp_in_t item;
    item.func       = func;
    item.unit_index = UnitIdxW'(unit);
    item.new_state  = StateW'(st);
    return item;
  endfunction

  // Mostly well-formed observes that follow a per-unit preferred transition,
  // so rows build up real majorities; queries and out-of-range states mixed in.
  function automatic mtp_in_t random_request();
    int unsigned unit;
    int unsigned roll;
    int unsigned prev;
    roll = $urandom_range(0, 99);
    unit = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
    prev = sb.last_seen[unit];
    if (roll < 20)
      return make_request(FuncQuery, unit, $urandom_range(0, 15));
    if (roll < 28)
      return make_request(FuncObserve, unit, $urandom_range(NumStates, 15));
    if (roll < 64)
      return make_request(FuncObserve, unit, (prev * 3 + unit) % NumStates);
    return make_request(FuncObserve, unit, $urandom_range(0, NumStates - 1));
  endfunction

  task automatic send_request(input mtp_in_t item);
    int unsigned gap;
    gap = in_gapless ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_request(item);
  endtask

  // Drop valid and wait until every predicted report has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_delay_step(input logic [StepW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.step = value;
    n_settings++;
  endtask

  initial begin
    int unsigned      p;
    int unsigned      k;
    logic [StepW-1:0] value;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset delay step.
    send_request(make_request(FuncQuery, 0, 0));      // empty row after reset
    send_request(make_request(FuncQuery, 0, 15));     // a query never flags the state
    send_request(make_request(FuncObserve, 0, 0));
    send_request(make_request(FuncObserve, 15, 9));
    send_request(make_request(FuncObserve, 15, 15));  // out of range, ignored
    send_request(make_request(FuncObserve, 15, 10));  // first out-of-range value
    send_request(make_request(FuncObserve, 15, 0));
    send_request(make_request(FuncQuery, 15, 7));
    // Tie between the last state and another one: the last state is kept.
    send_request(make_request(FuncObserve, 3, 4));
    send_request(make_request(FuncObserve, 3, 4));
    send_request(make_request(FuncObserve, 3, 7));
    send_request(make_request(FuncObserve, 3, 4));
    send_request(make_request(FuncQuery, 3, 0));
    // Tie not involving the last state: the lowest index wins.
    send_request(make_request(FuncObserve, 4, 5));
    send_request(make_request(FuncObserve, 4, 0));
    send_request(make_request(FuncObserve, 4, 2));
    send_request(make_request(FuncObserve, 4, 0));
    send_request(make_request(FuncObserve, 4, 5));
    send_request(make_request(FuncObserve, 4, 0));
    send_request(make_request(FuncObserve, 8, 8));
    send_request(make_request(FuncObserve, 8, 1));
    send_request(make_request(FuncObserve, 10, 9));
    send_request(make_request(FuncQuery, 10, 12));
    drain();

    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0:       value = '0;
        1:       value = '1;
        2:       value = 16'd1;
        default: value = StepW'($urandom_range(2, 65534));
      endcase
      write_delay_step(value);
      in_gapless  = (p % 3 == 1);
      out_gapless = (p % 3 == 2);
      for (k = 0; k < PhaseLen; k++) send_request(random_request());
      drain();
    end
    in_gapless  = 1'b0;
    out_gapless = 1'b0;
    repeat (60) @(posedge clk_i);

    $display("Covered %0d requests (%0d observes, %0d out of range) under %0d delay steps.",
             sb.n_requests, sb.n_observes, sb.n_out_of_range, n_settings);
    $display("Checked %0d reports, %0d of them on an empty row; %0d mismatches.",
             sb.n_checked, sb.n_empty_rows, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
